[sv/typed_value_range_intersect_unit_assert.svh]
// assertion macros for the typed value range intersect unit
// used by the port checker, no other dependencies
`ifndef TYPED_VALUE_RANGE_INTERSECT_UNIT_ASSERT_SVH
`define TYPED_VALUE_RANGE_INTERSECT_UNIT_ASSERT_SVH

// checked only while out of reset
`define TVRI_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tvri assertion failed");

// checked at every edge, reset included
`define TVRI_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("tvri assertion failed");

`endif

[sv/tvri_pkg.sv]
// shared types, type codes and helpers for the typed value range intersect unit
// used by every module of the block, no dependencies
package tvri_pkg;

  localparam int ValueWidth = 32;
  localparam int ShW        = $clog2(ValueWidth);
  localparam int QueueDepth = 2;

  typedef logic [ValueWidth-1:0] value_t;
  typedef logic [2:0]            type_code_t;

  localparam type_code_t TyNone   = 3'd0;
  localparam type_code_t TyBool   = 3'd1;
  localparam type_code_t TyInt    = 3'd2;
  localparam type_code_t TyUint   = 3'd3;
  localparam type_code_t TyIRange = 3'd4;
  localparam type_code_t TyURange = 3'd5;

  typedef struct packed {
    type_code_t  first_type;
    logic [31:0] first_low;
    logic [31:0] first_high;
    logic [31:0] first_step;
    type_code_t  second_type;
    logic [31:0] second_low;
    logic [31:0] second_high;
    logic [31:0] second_step;
  } in_item_t;

  typedef struct packed {
    logic        status;
    type_code_t  result_type;
    logic [31:0] result_low;
    logic [31:0] result_high;
    logic [31:0] result_step;
  } out_item_t;

  // classified item waiting for the gcd back end
  typedef struct packed {
    out_item_t item;
    logic      need_gcd;
    value_t    mag_a;
    value_t    mag_b;
  } q_entry_t;

  typedef enum logic [2:0] {
    BkIdle,
    BkFactor,
    BkOddA,
    BkLoop,
    BkDone
  } back_state_e;

  function automatic value_t order_key(value_t v, logic sg);
    value_t k;
    k = v;
    k[ValueWidth-1] = v[ValueWidth-1] ^ sg;
    return k;
  endfunction

  function automatic value_t magnitude(value_t v, logic sg);
    value_t m;
    m = (sg && v[ValueWidth-1]) ? (value_t'(0) - v) : v;
    return m;
  endfunction

endpackage

[sv/tvri_front.sv]
// front end: classifies a pair of typed values and forms the intersection
// apart from the step gcd; depends on tvri_pkg
module tvri_front (
  input  tvri_pkg::in_item_t item_i,
  output tvri_pkg::q_entry_t entry_o
);
  import tvri_pkg::*;

  always_comb begin
    type_code_t t1, t2, rt, ct;
    value_t     lo1, hi1, st1, lo2, hi2, st2;
    value_t     rlo, rhi, clo, chi, olo, ohi, ma, mb;
    logic       sg, swap, ok, ranges;
    type_code_t oty;

    t1  = item_i.first_type;
    t2  = item_i.second_type;
    lo1 = item_i.first_low;
    hi1 = item_i.first_high;
    st1 = item_i.first_step;
    lo2 = item_i.second_low;
    hi2 = item_i.second_high;
    st2 = item_i.second_step;

    sg     = 1'b0;
    swap   = 1'b0;
    ok     = 1'b0;
    ranges = 1'b0;
    oty    = TyNone;
    olo    = '0;
    ohi    = '0;
    rt     = t1;
    ct     = t2;
    rlo    = lo1;
    rhi    = hi1;
    clo    = lo2;
    chi    = hi2;

    if (t1 == TyNone || t2 == TyNone || t1 > TyURange || t2 > TyURange) begin
      ok = 1'b0;
    end else if (t1 == TyBool || t2 == TyBool) begin
      if (t1 == TyBool && t2 == TyBool && ((lo1 != '0) == (lo2 != '0))) begin
        ok  = 1'b1;
        oty = TyBool;
        olo = value_t'(lo1 != '0);
      end
    end else if (t1[0] != t2[0]) begin
      ok = 1'b0;
    end else begin
      sg   = ~t1[0];
      swap = t1 < t2;
      rt   = swap ? t2 : t1;
      ct   = swap ? t1 : t2;
      rlo  = swap ? lo2 : lo1;
      rhi  = swap ? hi2 : hi1;
      clo  = swap ? lo1 : lo2;
      chi  = swap ? hi1 : hi2;
      if (rt == TyInt || rt == TyUint) begin
        if (lo1 == lo2) begin
          ok  = 1'b1;
          oty = rt;
          olo = lo1;
        end
      end else if (ct == rt) begin
        if (!(order_key(rlo, sg) > order_key(chi, sg) ||
              order_key(clo, sg) > order_key(rhi, sg))) begin
          ok     = 1'b1;
          ranges = 1'b1;
          oty    = rt;
          olo    = (order_key(rlo, sg) >= order_key(clo, sg)) ? rlo : clo;
          ohi    = (order_key(rhi, sg) <= order_key(chi, sg)) ? rhi : chi;
        end
      end else begin
        if (order_key(clo, sg) >= order_key(rlo, sg) &&
            order_key(clo, sg) <= order_key(rhi, sg)) begin
          ok  = 1'b1;
          oty = ct;
          olo = clo;
        end
      end
    end

    ma = magnitude(st1, sg);
    mb = magnitude(st2, sg);

    entry_o.item.status      = ~ok;
    entry_o.item.result_type = oty;
    entry_o.item.result_low  = olo;
    entry_o.item.result_high = ohi;
    // a zero step makes the gcd the other step
    entry_o.item.result_step = ranges ? (ma | mb) : '0;
    entry_o.need_gcd         = ranges && (ma != '0) && (mb != '0);
    entry_o.mag_a            = ma;
    entry_o.mag_b            = mb;
  end

endmodule

[sv/tvri_fifo.sv]
// short queue between front and back end
// depends on tvri_pkg for the entry type and depth
module tvri_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  tvri_pkg::q_entry_t push_data_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output tvri_pkg::q_entry_t pop_data_o
);
  import tvri_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  q_entry_t        mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = count_q != CntW'(QueueDepth);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[sv/tvri_back.sv]
// back end: binary gcd of the range steps, one step per cycle, and the
// output register; depends on tvri_pkg
module tvri_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                pop_valid_i,
  output logic                pop_ready_o,
  input  tvri_pkg::q_entry_t  pop_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tvri_pkg::out_item_t out_data_o
);
  import tvri_pkg::*;

  back_state_e     state_q, state_d;
  value_t          a_q, b_q, lo, hi, diff;
  logic [ShW-1:0]  sh_q;
  out_item_t       hold_q, gcd_item;
  out_item_t       out_data_q;
  logic            out_valid_q, out_free;
  logic            pop, load_direct, load_gcd;

  assign out_free = !out_valid_q || out_ready_i;
  assign lo       = (a_q < b_q) ? a_q : b_q;
  assign hi       = (a_q < b_q) ? b_q : a_q;
  assign diff     = hi - lo;

  always_comb begin
    gcd_item             = hold_q;
    gcd_item.result_step = a_q << sh_q;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BkIdle: begin
        if (pop_valid_i && pop_data_i.need_gcd) begin
          state_d = BkFactor;
        end
      end
      BkFactor: begin
        if (a_q[0] || b_q[0]) begin
          state_d = BkOddA;
        end
      end
      BkOddA: begin
        if (a_q[0]) begin
          state_d = BkLoop;
        end
      end
      BkLoop: begin
        if (b_q[0] && diff == '0) begin
          state_d = BkDone;
        end
      end
      BkDone: begin
        if (out_free) begin
          state_d = BkIdle;
        end
      end
      default: state_d = BkIdle;
    endcase
  end

  // outputs
  always_comb begin
    pop_ready_o = 1'b0;
    load_direct = 1'b0;
    load_gcd    = 1'b0;
    unique case (state_q)
      BkIdle: begin
        pop_ready_o = pop_data_i.need_gcd || out_free;
        load_direct = pop_valid_i && !pop_data_i.need_gcd && out_free;
      end
      BkDone: begin
        load_gcd = out_free;
      end
      default: begin
        pop_ready_o = 1'b0;
      end
    endcase
  end

  assign pop = pop_valid_i && pop_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_direct || load_gcd) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_direct) begin
      out_data_q <= pop_data_i.item;
    end else if (load_gcd) begin
      out_data_q <= gcd_item;
    end
    if (state_q == BkIdle && pop && pop_data_i.need_gcd) begin
      a_q    <= pop_data_i.mag_a;
      b_q    <= pop_data_i.mag_b;
      sh_q   <= '0;
      hold_q <= pop_data_i.item;
    end else if (state_q == BkFactor && !(a_q[0] || b_q[0])) begin
      a_q  <= a_q >> 1;
      b_q  <= b_q >> 1;
      sh_q <= sh_q + 1'b1;
    end else if (state_q == BkOddA && !a_q[0]) begin
      a_q <= a_q >> 1;
    end else if (state_q == BkLoop) begin
      if (!b_q[0]) begin
        b_q <= b_q >> 1;
      end else begin
        a_q <= lo;
        b_q <= diff;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[sv/typed_value_range_intersect_unit.sv]
// path: an item that needs no gcd passes through the queue and then the output
// register; two overlapping ranges with nonzero steps also run the
// one-step-per-cycle binary gcd loop in the back end
// throughput: one item per gcd run, a two-entry queue lets the front keep taking
// reset: asynchronous active low, clears queue, gcd state and output valid
module typed_value_range_intersect_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tvri_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tvri_pkg::out_item_t out_data_o
);
  import tvri_pkg::*;

  q_entry_t front_entry, queue_entry;
  logic     queue_valid, queue_ready;

  tvri_front u_front (
    .item_i  (in_data_i),
    .entry_o (front_entry)
  );

  tvri_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_data_i  (front_entry),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready),
    .pop_data_o   (queue_entry)
  );

  tvri_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (queue_valid),
    .pop_ready_o (queue_ready),
    .pop_data_i  (queue_entry),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[sv/tvri_checker.sv]
// port checker for the typed value range intersect unit, bound to the top
// depends on tvri_pkg and typed_value_range_intersect_unit_assert.svh
`include "typed_value_range_intersect_unit_assert.svh"

module tvri_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input tvri_pkg::in_item_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input tvri_pkg::out_item_t out_data_o
);
  import tvri_pkg::*;

  logic tail_zero, out_zero, scalar_found;

  assign tail_zero    = out_data_o.result_high == '0 && out_data_o.result_step == '0;
  assign out_zero     = out_data_o.result_type == TyNone && out_data_o.result_low == '0 &&
                        tail_zero;
  assign scalar_found = !out_data_o.status && (out_data_o.result_type == TyBool ||
                        out_data_o.result_type == TyInt || out_data_o.result_type == TyUint);

  `TVRI_ASSERT_ALWAYS(a_no_out_in_reset, !rst_ni |-> !out_valid_o)
  `TVRI_ASSERT(a_in_held, in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
  `TVRI_ASSERT(a_out_held, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
  `TVRI_ASSERT(a_no_common_zero, out_valid_o && out_data_o.status |-> out_zero)
  `TVRI_ASSERT(a_scalar_zero, out_valid_o && scalar_found |-> tail_zero)

endmodule

bind typed_value_range_intersect_unit tvri_checker u_tvri_checker (.*);
